// File: sv/byte_level_utf8_transcoder_top_assert.svh
// ---------------------------------------------------------------------------
// byte_level_utf8_transcoder_top_assert.svh
// assertion macros shared by the queue and back-end modules
// ---------------------------------------------------------------------------
`ifndef BYTE_LEVEL_UTF8_TRANSCODER_TOP_ASSERT_SVH
`define BYTE_LEVEL_UTF8_TRANSCODER_TOP_ASSERT_SVH

// expr must never hold outside reset
`define BLUT_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// same-cycle implication
`define BLUT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BLUT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/blut_pkg.sv
// ---------------------------------------------------------------------------
// blut_pkg
// types, constants and mapping functions of the byte-level utf-8 transcoder
// ---------------------------------------------------------------------------
package blut_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int CFG_ADDR_W      = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_DIRECTION = 2'd0;

  localparam logic DIR_ENCODE = 1'b0;  // raw bytes to byte-level utf-8
  localparam logic DIR_DECODE = 1'b1;  // byte-level utf-8 to raw bytes

  localparam logic [7:0] PRINT_LO_A = 8'd33;
  localparam logic [7:0] PRINT_HI_A = 8'd126;
  localparam logic [7:0] PRINT_LO_B = 8'd161;
  localparam logic [7:0] PRINT_HI_B = 8'd172;
  localparam logic [7:0] PRINT_LO_C = 8'd174;
  localparam logic [7:0] SOFT_HYPHEN = 8'd173;
  localparam logic [7:0] CTRL_HI    = 8'd32;
  localparam logic [7:0] HIGH_CTRL_HI = 8'd160;
  localparam logic [8:0] SHIFT_OFS  = 9'd256;
  localparam logic [8:0] HIGH_OFS   = 9'd162;
  localparam logic [8:0] HYPHEN_CP  = 9'd323;
  localparam logic [7:0] BAD_LEAD_CP = 8'h3F;

  localparam logic [20:0] CP_1B_LIM = 21'h80;
  localparam logic [20:0] CP_2B_LIM = 21'h800;
  localparam logic [20:0] CP_3B_LIM = 21'h10000;

  typedef struct packed {
    logic        mode;
    logic [20:0] cp;
    logic        text_end;
  } job_t;

  typedef struct packed {
    logic       wr;
    logic       dir;
  } cfg_wr_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] raw;
  } raw_t;

  typedef struct packed {
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } utf8_t;

  function automatic logic [8:0] byte_to_cp(input logic [7:0] b);
    logic [8:0] cp;
    if ((b >= PRINT_LO_A && b <= PRINT_HI_A) || (b >= PRINT_LO_B && b <= PRINT_HI_B) ||
        b >= PRINT_LO_C) begin
      cp = {1'b0, b};
    end else if (b <= CTRL_HI) begin
      cp = SHIFT_OFS | {1'b0, b};
    end else if (b <= HIGH_CTRL_HI) begin
      cp = {1'b0, b} + HIGH_OFS;
    end else begin
      cp = HYPHEN_CP;
    end
    return cp;
  endfunction

  function automatic raw_t cp_to_byte(input logic [20:0] cp);
    raw_t  r;
    logic [8:0] lo;
    logic  small_cp;
    lo       = cp[8:0];
    small_cp = (cp[20:9] == '0);
    r.hit = 1'b0;
    r.raw = cp[7:0];
    if (small_cp) begin
      if (!lo[8] && ((lo[7:0] >= PRINT_LO_A && lo[7:0] <= PRINT_HI_A) ||
          (lo[7:0] >= PRINT_LO_B && lo[7:0] <= PRINT_HI_B) || lo[7:0] >= PRINT_LO_C)) begin
        r.hit = 1'b1;
      end else if (lo >= SHIFT_OFS && lo <= (SHIFT_OFS + 9'(CTRL_HI))) begin
        r.hit = 1'b1;  // low byte already equals cp - 256
      end else if (lo > (SHIFT_OFS + 9'(CTRL_HI)) && lo < HYPHEN_CP) begin
        r.hit = 1'b1;
        r.raw = 8'(lo - HIGH_OFS);
      end else if (lo == HYPHEN_CP) begin
        r.hit = 1'b1;
        r.raw = SOFT_HYPHEN;
      end
    end
    return r;
  endfunction

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t u;
    u.bytes = '0;
    if (cp < CP_1B_LIM) begin
      u.last_idx = 2'd0;
      u.bytes[0] = cp[7:0];
    end else if (cp < CP_2B_LIM) begin
      u.last_idx = 2'd1;
      u.bytes[0] = {3'b110, cp[10:6]};
      u.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < CP_3B_LIM) begin
      u.last_idx = 2'd2;
      u.bytes[0] = {4'b1110, cp[15:12]};
      u.bytes[1] = {2'b10, cp[11:6]};
      u.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      u.last_idx = 2'd3;
      u.bytes[0] = {5'b11110, cp[20:18]};
      u.bytes[1] = {2'b10, cp[17:12]};
      u.bytes[2] = {2'b10, cp[11:6]};
      u.bytes[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

endpackage

// File: sv/blut_if.sv
// ---------------------------------------------------------------------------
// blut_if
// valid/ready stream interfaces for input bytes and output bytes
// ---------------------------------------------------------------------------
interface blut_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, in_byte, text_end, input ready);
  modport sink   (input valid, in_byte, text_end, output ready);
endinterface

interface blut_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       text_done;

  modport source (output valid, out_byte, run_last, text_done, input ready);
  modport sink   (input valid, out_byte, run_last, text_done, output ready);
endinterface

// File: sv/blut_front.sv
// ---------------------------------------------------------------------------
// blut_front
// accepts input bytes, tracks utf-8 decode state, hands code points to the queue
// ---------------------------------------------------------------------------
module blut_front import blut_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  blut_in_if.sink       in_ch,
  input  cfg_wr_t       cfg,
  output logic          dir_o,
  input  logic          q_full,
  output logic          push,
  output job_t          push_job
);

  logic        dir_r;
  logic [20:0] partial_r, partial_nxt;
  logic [1:0]  pending_r, pending_nxt;
  logic [20:0] cp_dec;
  logic [1:0]  left;
  logic        accept;
  logic        hold;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign dir_o       = dir_r;

  always_comb begin
    cp_dec = '0;
    left   = 2'd0;
    if (pending_r == 2'd0) begin
      priority if (!in_ch.in_byte[7]) begin
        cp_dec = {13'd0, in_ch.in_byte};
      end else if (in_ch.in_byte[7:5] == 3'b110) begin
        cp_dec = {16'd0, in_ch.in_byte[4:0]};
        left   = 2'd1;
      end else if (in_ch.in_byte[7:4] == 4'b1110) begin
        cp_dec = {17'd0, in_ch.in_byte[3:0]};
        left   = 2'd2;
      end else if (in_ch.in_byte[7:3] == 5'b11110) begin
        cp_dec = {18'd0, in_ch.in_byte[2:0]};
        left   = 2'd3;
      end else begin
        cp_dec = {13'd0, BAD_LEAD_CP};  // stray continuation or bad lead
      end
    end else begin
      // continuation top bits are not checked
      cp_dec = {partial_r[14:0], in_ch.in_byte[5:0]};
      left   = pending_r - 2'd1;
    end

    hold = (dir_r == DIR_DECODE) && (left != 2'd0) && !in_ch.text_end;
    push = accept && !hold;

    push_job.mode     = dir_r;
    push_job.text_end = in_ch.text_end;
    push_job.cp       = (dir_r == DIR_DECODE) ? cp_dec
                                              : {12'd0, byte_to_cp(in_ch.in_byte)};

    partial_nxt = partial_r;
    pending_nxt = pending_r;
    if (cfg.wr) begin
      partial_nxt = '0;
      pending_nxt = 2'd0;
    end else if (accept) begin
      partial_nxt = hold ? cp_dec : '0;
      pending_nxt = hold ? left : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r     <= DIR_ENCODE;
      partial_r <= '0;
      pending_r <= 2'd0;
    end else begin
      if (cfg.wr) begin
        dir_r <= cfg.dir;
      end
      partial_r <= partial_nxt;
      pending_r <= pending_nxt;
    end
  end

endmodule

// File: sv/blut_queue.sv
// ---------------------------------------------------------------------------
// blut_queue
// short fifo of decoded jobs between front and back
// ---------------------------------------------------------------------------
module blut_queue import blut_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`include "byte_level_utf8_transcoder_top_assert.svh"

  `BLUT_ASSERT_NEVER(a_q_no_overflow, push && full, "push into full queue")
  `BLUT_ASSERT_NEVER(a_q_no_underflow, pop && empty, "pop from empty queue")
  `BLUT_ASSERT_NEVER(a_q_count_range, count_r > CNT_W'(DEPTH), "queue count out of range")

endmodule

// File: sv/blut_back.sv
// ---------------------------------------------------------------------------
// blut_back
// maps each queued code point to output bytes, one byte per cycle unless the output stalls
// ---------------------------------------------------------------------------
module blut_back import blut_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  job_t       head,
  output logic       pop,
  blut_out_if.source out_ch
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_byte_r;
  logic       run_last_r;
  logic       text_done_r;
  raw_t       raw;
  utf8_t      enc;
  utf8_t      plan;
  logic       emit;
  logic       last;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.run_last  = run_last_r;
  assign out_ch.text_done = text_done_r;

  always_comb begin
    raw = cp_to_byte(head.cp);
    enc = utf8_encode(head.cp);
    if (head.mode == DIR_DECODE && raw.hit) begin
      plan.last_idx = 2'd0;
      plan.bytes    = {24'd0, raw.raw};
    end else begin
      plan = enc;
    end
    emit    = !q_empty && (!out_valid_r || out_ch.ready);
    last    = (idx_r == plan.last_idx);
    pop     = emit && last;
    idx_nxt = idx_r;
    if (emit) begin
      idx_nxt = last ? 2'd0 : idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r  <= plan.bytes[idx_r];
      run_last_r  <= last;
      text_done_r <= last && head.text_end;
    end
  end

`include "byte_level_utf8_transcoder_top_assert.svh"

  `BLUT_ASSERT_IMPL(a_idx_in_run, !q_empty, idx_r <= plan.last_idx,
                    "byte index past end of run")
  `BLUT_ASSERT_IMPL(a_done_is_last, out_valid_r && text_done_r, run_last_r,
                    "text_done without run_last")
  `BLUT_ASSERT_NEXT(a_idx_steps, emit && !last, idx_r == $past(idx_r) + 2'd1,
                    "byte index did not advance")

endmodule

// File: sv/byte_level_utf8_transcoder_top.sv
// ---------------------------------------------------------------------------
// byte_level_utf8_transcoder_top
// byte-level tokenizer alphabet transcoder, raw bytes <-> printable utf-8
// ---------------------------------------------------------------------------
// The input takes one byte per cycle while the job queue (QUEUE_DEPTH entries)
// has room. Each input byte yields 0 to 4 output bytes; the back end writes
// one output byte per cycle into the output register while the output is
// not stalled. Longer runs, two bytes in encode direction or up to four when
// decoding re-encodes an unmapped code point, fill the queue and hold off
// the input. Register direction (byte address 0, bit 0) selects the way;
// writing it clears any code point half decoded. The user must write it only
// while no item is in flight; the block itself does not enforce this.
module byte_level_utf8_transcoder_top import blut_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  blut_in_if.sink               in_ch,
  blut_out_if.source            out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_wr_t cfg;
  logic    dir;
  logic    push;
  job_t    push_job;
  logic    q_full;
  logic    q_empty;
  logic    pop;
  job_t    head;

  assign pready  = 1'b1;
  assign cfg.wr  = psel && penable && pwrite && pready && (paddr == ADDR_DIRECTION);
  assign cfg.dir = pwdata[0];
  assign prdata  = (paddr == ADDR_DIRECTION) ? {{(CFG_DATA_W-1){1'b0}}, dir} : '0;

  blut_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg),
    .dir_o    (dir),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  blut_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  blut_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
